>>> rtl/cpr_pkg.sv
// Shared types, codes and constants of the clock page replacer.
package cpr_pkg;

    localparam int NUM_FRAMES_DEFAULT = 64;

    localparam int OP_W    = 2;
    localparam int FRAME_W = 6;
    localparam int COUNT_W = 7;

    localparam logic [OP_W-1:0] OP_VICTIM = 2'd0;
    localparam logic [OP_W-1:0] OP_PIN    = 2'd1;
    localparam logic [OP_W-1:0] OP_UNPIN  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic present;
        logic referenced;
    } entry_t;

    typedef struct packed {
        logic clear_step;
        logic latch;
        logic update;
        logic sweep;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic count_zero;
        logic frame_ok;
        logic evict;
        logic out_free;
    } status_t;

endpackage

>>> rtl/cpr_if.sv
// Valid/ready channel interfaces for request and result words.
interface cpr_in_if;
    logic                        valid;
    logic                        ready;
    logic [cpr_pkg::OP_W-1:0]    op;
    logic [cpr_pkg::FRAME_W-1:0] frame;

    modport source (output valid, output op, output frame, input ready);
    modport sink   (input valid, input op, input frame, output ready);
endinterface

interface cpr_out_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [cpr_pkg::FRAME_W-1:0] victim_frame;
    logic [cpr_pkg::COUNT_W-1:0] evictable_count;

    modport source (output valid, output found, output victim_frame,
                    output evictable_count, input ready);
    modport sink   (input valid, input found, input victim_frame,
                    input evictable_count, output ready);
endinterface

>>> rtl/cpr_ctrl.sv
// Controller state machine of the clock page replacer.
module cpr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [cpr_pkg::OP_W-1:0] in_op,
    input  cpr_pkg::status_t  status,
    output logic              in_ready,
    output cpr_pkg::cmd_t     cmd
);

    cpr_pkg::state_t state_reg;
    cpr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cpr_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            cpr_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = cpr_pkg::ST_IDLE;
                end
            end
            cpr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    priority if (in_op == cpr_pkg::OP_VICTIM)
                    begin
                        state_next = status.count_zero ? cpr_pkg::ST_FINISH
                                                       : cpr_pkg::ST_SWEEP;
                    end
                    else if ((in_op == cpr_pkg::OP_PIN || in_op == cpr_pkg::OP_UNPIN)
                             && status.frame_ok)
                    begin
                        state_next = cpr_pkg::ST_UPDATE;
                    end
                    else
                    begin
                        state_next = cpr_pkg::ST_FINISH;
                    end
                end
            end
            cpr_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = cpr_pkg::ST_FINISH;
            end
            cpr_pkg::ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (status.evict)
                begin
                    state_next = cpr_pkg::ST_FINISH;
                end
            end
            cpr_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = cpr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cpr_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

>>> rtl/cpr_dpath.sv
// Datapath of the clock page replacer: frame bit memory, hand, count and result register.
module cpr_dpath #(
    parameter int NUM_FRAMES = cpr_pkg::NUM_FRAMES_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cpr_pkg::cmd_t               cmd,
    input  logic [cpr_pkg::OP_W-1:0]    in_op,
    input  logic [cpr_pkg::FRAME_W-1:0] in_frame,
    input  logic                        out_ready,
    output cpr_pkg::status_t            status,
    output logic                        out_valid,
    output logic                        out_found,
    output logic [cpr_pkg::FRAME_W-1:0] out_victim_frame,
    output logic [cpr_pkg::COUNT_W-1:0] out_evictable_count
);

    localparam int AW  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW  = $clog2(NUM_FRAMES + 1);
    localparam int XW  = (AW > cpr_pkg::FRAME_W) ? AW : cpr_pkg::FRAME_W;
    localparam int XCW = (CW > cpr_pkg::COUNT_W) ? CW : cpr_pkg::COUNT_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_FRAMES - 1);

    cpr_pkg::entry_t mem [NUM_FRAMES];

    logic [AW-1:0]           clr_cnt_reg;
    logic [AW-1:0]           hand_reg;
    logic [CW-1:0]           count_reg;
    logic [cpr_pkg::OP_W-1:0] op_reg;
    logic [AW-1:0]           addr_reg;
    cpr_pkg::entry_t         rdata_reg;
    logic                    found_reg;
    logic [AW-1:0]           chosen_reg;
    logic                    out_valid_reg;
    logic                    out_found_reg;
    logic [cpr_pkg::FRAME_W-1:0] out_frame_reg;
    logic [cpr_pkg::COUNT_W-1:0] out_count_reg;

    logic [AW-1:0]           clr_cnt_next;
    logic [AW-1:0]           hand_next;
    logic [CW-1:0]           count_next;
    logic [AW-1:0]           addr_next;
    logic                    found_next;
    logic [AW-1:0]           chosen_next;
    logic                    out_valid_next;

    logic [XW-1:0]           frame_x;
    logic [AW-1:0]           frame_addr;
    logic [AW-1:0]           sweep_next_addr;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    cpr_pkg::entry_t         wr_data;
    logic                    evict;
    logic [XW-1:0]           chosen_x;
    logic [XCW-1:0]          count_x;

    assign frame_x         = XW'(in_frame);
    assign frame_addr      = frame_x[AW-1:0];
    assign sweep_next_addr = (addr_reg == LAST_ADDR) ? '0 : addr_reg + AW'(1);
    assign evict           = rdata_reg.present & ~rdata_reg.referenced;
    assign chosen_x        = XW'(chosen_reg);
    assign count_x         = XCW'(count_reg);

    assign status.clear_last = (clr_cnt_reg == LAST_ADDR);
    assign status.count_zero = (count_reg == '0);
    assign status.frame_ok   = (32'(in_frame) < 32'(NUM_FRAMES));
    assign status.evict      = evict;
    assign status.out_free   = ~out_valid_reg | out_ready;

    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        hand_next      = hand_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        found_next     = found_reg;
        chosen_next    = chosen_reg;
        rd_en          = 1'b0;
        rd_addr        = addr_reg;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_data        = '0;

        if (cmd.clear_step)
        begin
            wr_en        = 1'b1;
            wr_addr      = clr_cnt_reg;
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end

        if (cmd.latch)
        begin
            rd_en       = 1'b1;
            rd_addr     = (in_op == cpr_pkg::OP_VICTIM) ? hand_reg : frame_addr;
            addr_next   = rd_addr;
            found_next  = 1'b0;
            chosen_next = '0;
        end

        if (cmd.update)
        begin
            if (op_reg == cpr_pkg::OP_PIN && rdata_reg.present)
            begin
                wr_en      = 1'b1;
                wr_data    = '0;
                count_next = count_reg - CW'(1);
            end
            else if (op_reg == cpr_pkg::OP_UNPIN && !rdata_reg.present)
            begin
                wr_en      = 1'b1;
                wr_data    = '{present: 1'b1, referenced: 1'b1};
                count_next = count_reg + CW'(1);
            end
        end

        if (cmd.sweep)
        begin
            if (evict)
            begin
                wr_en       = 1'b1;
                wr_data     = '0;
                count_next  = count_reg - CW'(1);
                hand_next   = addr_reg;
                found_next  = 1'b1;
                chosen_next = addr_reg;
            end
            else
            begin
                wr_en     = rdata_reg.present;
                wr_data   = '{present: 1'b1, referenced: 1'b0};
                rd_en     = 1'b1;
                rd_addr   = sweep_next_addr;
                addr_next = sweep_next_addr;
            end
        end

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg & ~out_ready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            hand_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            hand_reg      <= hand_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg <= in_op;
        end
        addr_reg   <= addr_next;
        found_reg  <= found_next;
        chosen_reg <= chosen_next;
        if (cmd.load_out)
        begin
            out_found_reg <= found_reg;
            out_frame_reg <= chosen_x[cpr_pkg::FRAME_W-1:0];
            out_count_reg <= count_x[cpr_pkg::COUNT_W-1:0];
        end
    end

    assign out_valid           = out_valid_reg;
    assign out_found           = out_found_reg;
    assign out_victim_frame    = out_frame_reg;
    assign out_evictable_count = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(NUM_FRAMES))
        else $error("present count exceeds frame count");

    a_hand_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(hand_reg) < 32'(NUM_FRAMES))
        else $error("clock hand out of range");

    a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sweep && evict) |-> (count_reg != '0))
        else $error("eviction with an empty replacer");

    a_evict_hand: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sweep && evict) |=> (found_reg && hand_reg == chosen_reg))
        else $error("hand does not rest on the evicted frame");

endmodule

>>> rtl/clock_page_replacer_top.sv
// Top level of the clock page replacer.
//
// The request channel carries one word per operation: op selects victim, pin or
// unpin, and frame names the frame for pin and unpin. The result channel returns
// exactly one word per request with found, victim_frame and evictable_count.
// Requests are taken one at a time. Unused codes, out-of-range frames and a victim
// request on an empty replacer go straight to the finish state, and pin or unpin
// of a valid frame passes through the update state first. Otherwise the victim
// sweep visits one frame per cycle through the memory read port, from 1 up to
// 2 * NUM_FRAMES frames, until it finds a present, unreferenced frame. The next
// request is taken the cycle after a result is loaded, even while that result
// still waits for the receiver.
// After reset the block clears the frame bit memory one frame at a time
// and holds ready low meanwhile. When the receiver stalls, a finished result
// stays in the output register and the next result waits until it is taken.
module clock_page_replacer_top #(
    parameter int NUM_FRAMES = cpr_pkg::NUM_FRAMES_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    cpr_in_if.sink     in_ch,
    cpr_out_if.source  out_ch
);

    cpr_pkg::cmd_t    cmd;
    cpr_pkg::status_t status;

    cpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_op    (in_ch.op),
        .status   (status),
        .in_ready (in_ch.ready),
        .cmd      (cmd)
    );

    cpr_dpath #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_dpath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .in_op               (in_ch.op),
        .in_frame            (in_ch.frame),
        .out_ready           (out_ch.ready),
        .status              (status),
        .out_valid           (out_ch.valid),
        .out_found           (out_ch.found),
        .out_victim_frame    (out_ch.victim_frame),
        .out_evictable_count (out_ch.evictable_count)
    );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the clock page replacer, with directed and random request words.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_FRAMES  = cpr_pkg::NUM_FRAMES_DEFAULT;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_WORDS = 460;
    localparam int N_DIRECTED  = 23;

    localparam logic [cpr_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic                        found;
        logic [cpr_pkg::FRAME_W-1:0] victim_frame;
        logic [cpr_pkg::COUNT_W-1:0] evictable_count;
    } replace_result_t;

    typedef struct packed {
        logic [cpr_pkg::OP_W-1:0]    op;
        logic [cpr_pkg::FRAME_W-1:0] frame;
        logic                        fixed;
        replace_result_t             res;
    } stim_row_t;

    logic clk;
    logic rst_n;

    cpr_in_if  in_ch ();
    cpr_out_if out_ch ();

    clock_page_replacer_top #(
        .NUM_FRAMES (NUM_FRAMES)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    logic frame_present    [NUM_FRAMES];
    logic frame_referenced [NUM_FRAMES];
    int   hand_pos;
    int   present_total;

    replace_result_t awaited_results[$];

    int mismatches    = 0;
    int words_sent    = 0;
    int cycle_count   = 0;
    int send_idle_pct = 36;
    int recv_idle_pct = 64;
    int holds_asked   = 0;
    int holds_done    = 0;
    int evictions     = 0;
    int empty_victims = 0;
    int longest_sweep = 0;
    int peak_present  = 0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{cpr_pkg::OP_VICTIM, 6'd0,  1'b1, '{1'b0, 6'd0,  7'd0}},
        '{cpr_pkg::OP_PIN,    6'd5,  1'b1, '{1'b0, 6'd0,  7'd0}},
        '{OP_UNUSED,          6'd63, 1'b1, '{1'b0, 6'd0,  7'd0}},
        '{cpr_pkg::OP_UNPIN,  6'd0,  1'b1, '{1'b0, 6'd0,  7'd1}},
        '{cpr_pkg::OP_UNPIN,  6'd63, 1'b1, '{1'b0, 6'd0,  7'd2}},
        '{cpr_pkg::OP_UNPIN,  6'd63, 1'b1, '{1'b0, 6'd0,  7'd2}},
        '{cpr_pkg::OP_VICTIM, 6'd42, 1'b1, '{1'b1, 6'd0,  7'd1}},
        '{cpr_pkg::OP_VICTIM, 6'd21, 1'b1, '{1'b1, 6'd63, 7'd0}},
        '{cpr_pkg::OP_VICTIM, 6'd63, 1'b1, '{1'b0, 6'd0,  7'd0}},
        '{cpr_pkg::OP_UNPIN,  6'd10, 1'b0, '0},
        '{cpr_pkg::OP_UNPIN,  6'd20, 1'b0, '0},
        '{cpr_pkg::OP_PIN,    6'd10, 1'b0, '0},
        '{cpr_pkg::OP_PIN,    6'd10, 1'b0, '0},
        '{cpr_pkg::OP_UNPIN,  6'd10, 1'b0, '0},
        '{cpr_pkg::OP_VICTIM, 6'd0,  1'b0, '0},
        '{OP_UNUSED,          6'd0,  1'b0, '0},
        '{cpr_pkg::OP_UNPIN,  6'd33, 1'b0, '0},
        '{cpr_pkg::OP_VICTIM, 6'd7,  1'b0, '0},
        '{cpr_pkg::OP_VICTIM, 6'd56, 1'b0, '0},
        '{cpr_pkg::OP_UNPIN,  6'd1,  1'b0, '0},
        '{cpr_pkg::OP_PIN,    6'd1,  1'b0, '0},
        '{cpr_pkg::OP_UNPIN,  6'd1,  1'b0, '0},
        '{cpr_pkg::OP_VICTIM, 6'd63, 1'b0, '0}
    };

    function automatic replace_result_t clock_replace(
        input logic [cpr_pkg::OP_W-1:0]    op,
        input logic [cpr_pkg::FRAME_W-1:0] fr
    );
        replace_result_t r;
        int steps;
        r = '0;
        if (op == cpr_pkg::OP_VICTIM)
        begin
            if (present_total == 0)
            begin
                empty_victims++;
            end
            else
            begin
                steps = 0;
                while (!r.found && steps <= 2 * NUM_FRAMES)
                begin
                    steps++;
                    if (frame_present[hand_pos])
                    begin
                        if (frame_referenced[hand_pos])
                        begin
                            frame_referenced[hand_pos] = 1'b0;
                        end
                        else
                        begin
                            frame_present[hand_pos] = 1'b0;
                            present_total--;
                            r.found = 1'b1;
                            r.victim_frame = cpr_pkg::FRAME_W'(hand_pos);
                        end
                    end
                    if (!r.found)
                    begin
                        hand_pos = (hand_pos + 1) % NUM_FRAMES;
                    end
                end
                if (steps > longest_sweep)
                begin
                    longest_sweep = steps;
                end
                if (r.found)
                begin
                    evictions++;
                end
            end
        end
        else if (op == cpr_pkg::OP_PIN)
        begin
            if (int'(fr) < NUM_FRAMES && frame_present[fr])
            begin
                frame_present[fr] = 1'b0;
                frame_referenced[fr] = 1'b0;
                present_total--;
            end
        end
        else if (op == cpr_pkg::OP_UNPIN)
        begin
            if (int'(fr) < NUM_FRAMES && !frame_present[fr])
            begin
                frame_present[fr] = 1'b1;
                frame_referenced[fr] = 1'b1;
                present_total++;
            end
        end
        if (present_total > peak_present)
        begin
            peak_present = present_total;
        end
        r.evictable_count = cpr_pkg::COUNT_W'(present_total);
        return r;
    endfunction

    task automatic send_word(input logic [cpr_pkg::OP_W-1:0] op,
                             input logic [cpr_pkg::FRAME_W-1:0] fr,
                             input logic fixed = 1'b0,
                             input replace_result_t fixed_res = '0);
        replace_result_t predicted;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_ch.valid <= 1'b1;
        in_ch.op    <= op;
        in_ch.frame <= fr;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predicted = clock_replace(op, fr);
        awaited_results.push_back(fixed ? fixed_res : predicted);
        words_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic random_segment();
        int kind;
        int pick;
        int j;
        int k;
        logic [cpr_pkg::FRAME_W-1:0] order [NUM_FRAMES];
        logic [cpr_pkg::FRAME_W-1:0] tmp;
        logic [cpr_pkg::OP_W-1:0]    op;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            for (j = 0; j < NUM_FRAMES; j++)
            begin
                order[j] = cpr_pkg::FRAME_W'(j);
            end
            for (j = NUM_FRAMES - 1; j > 0; j--)
            begin
                k = $urandom_range(0, j);
                tmp = order[j];
                order[j] = order[k];
                order[k] = tmp;
            end
            for (j = 0; j < NUM_FRAMES; j++)
            begin
                send_word(cpr_pkg::OP_UNPIN, order[j]);
            end
            send_word(cpr_pkg::OP_VICTIM, cpr_pkg::FRAME_W'($urandom_range(0, 63)));
        end
        else
        begin
            repeat ($urandom_range(10, 40))
            begin
                pick = $urandom_range(0, 99);
                if (pick < (kind < 6 ? 45 : 20))
                begin
                    op = cpr_pkg::OP_UNPIN;
                end
                else if (pick < (kind < 6 ? 60 : 40))
                begin
                    op = cpr_pkg::OP_PIN;
                end
                else if (pick < 97)
                begin
                    op = cpr_pkg::OP_VICTIM;
                end
                else
                begin
                    op = OP_UNUSED;
                end
                send_word(op, cpr_pkg::FRAME_W'($urandom_range(0, 63)));
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, awaited_results.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_asked)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        replace_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected result word: found %0d victim_frame %0d count %0d",
                             out_ch.found, out_ch.victim_frame, out_ch.evictable_count);
                end
            end
            else
            begin
                want = awaited_results.pop_front();
                if (out_ch.found !== want.found || out_ch.victim_frame !== want.victim_frame
                        || out_ch.evictable_count !== want.evictable_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch: found %0d/%0d victim_frame %0d/%0d count %0d/%0d",
                                 want.found, out_ch.found, want.victim_frame,
                                 out_ch.victim_frame, want.evictable_count,
                                 out_ch.evictable_count);
                    end
                end
            end
        end
    end

    initial
    begin
        int i;
        int phase;
        int target;
        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.op    <= cpr_pkg::OP_VICTIM;
        in_ch.frame <= '0;
        for (i = 0; i < NUM_FRAMES; i++)
        begin
            frame_present[i] = 1'b0;
            frame_referenced[i] = 1'b0;
        end
        hand_pos = 0;
        present_total = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIRECTED; i++)
        begin
            send_word(directed_rows[i].op, directed_rows[i].frame,
                      directed_rows[i].fixed, directed_rows[i].res);
        end
        wait_drained();

        target = words_sent;
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 64 : 0;
            recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 36 : 0;
            if (phase < 2)
            begin
                holds_asked++;
            end
            target += PHASE_WORDS;
            while (words_sent < target)
            begin
                random_segment();
            end
            wait_drained();
        end

        repeat (2 * NUM_FRAMES + 8) @(posedge clk);

        $display("Sent %0d words: %0d evictions, %0d victims on an empty replacer.",
                 words_sent, evictions, empty_victims);
        $display("Longest sweep %0d frames, peak of %0d present frames, %0d mismatches.",
                 longest_sweep, peak_present, mismatches);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> clock_page_replacer_top.f
rtl/cpr_pkg.sv
rtl/cpr_if.sv
rtl/cpr_ctrl.sv
rtl/cpr_dpath.sv
rtl/clock_page_replacer_top.sv
tb/testbench.sv
